// ===== src/arpsd_pkg.sv =====
// Package for the ARP binding spoof detector: sizes, status codes and beat types.
// Depends on nothing; every other file of the block imports it.
package arpsd_pkg;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned REPORT_DEPTH = 16;

  localparam int unsigned TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RPT_AW = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
  localparam int unsigned TBL_CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RPT_CW = $clog2(REPORT_DEPTH + 1);
  localparam int unsigned SCAN_W = (TBL_CW > RPT_CW) ? TBL_CW : RPT_CW;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W  = 32;
  localparam int unsigned OPC_W = 16;

  localparam logic [OPC_W-1:0] OP_REPLY = 16'd2;

  typedef enum logic [0:0] {
    FUNC_LEARN = 1'b0,
    FUNC_CHECK = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_NOT_REPLY  = 4'd0,
    ST_MISMATCH   = 4'd1,
    ST_LEARNED    = 4'd2,
    ST_UPDATED    = 4'd3,
    ST_FULL       = 4'd4,
    ST_CONSISTENT = 4'd5,
    ST_NEW_DEVICE = 4'd6,
    ST_ALERT      = 4'd7,
    ST_REPORTED   = 4'd8
  } status_e;

  typedef struct packed {
    logic              func;
    logic [OPC_W-1:0]  opcode;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   sender_ip;
    logic [IP_W-1:0]   probed_ip;
  } arpsd_in_t;

  typedef struct packed {
    status_e           status;
    logic [MAC_W-1:0]  legit_mac;
    logic              legit_found;
    logic [TBL_CW-1:0] entry_count;
  } arpsd_out_t;

  typedef struct packed {
    logic              rd_en;
    logic [TBL_AW-1:0] rd_addr;
    logic              wr_en;
    logic              set_valid;
    logic [TBL_AW-1:0] wr_addr;
    logic [MAC_W-1:0]  wr_mac;
    logic [IP_W-1:0]   wr_ip;
  } bind_req_t;

  typedef struct packed {
    logic [MAC_W-1:0]  rd_mac;
    logic [IP_W-1:0]   rd_ip;
    logic              rd_valid;
    logic [TBL_CW-1:0] count;
  } bind_rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [RPT_AW-1:0] rd_addr;
    logic              append;
    logic [IP_W-1:0]   wr_ip;
  } rpt_req_t;

  typedef struct packed {
    logic [IP_W-1:0]   rd_ip;
    logic [RPT_CW-1:0] count;
  } rpt_rsp_t;

endpackage

// ===== src/arpsd_bind_tbl.sv =====
// Binding table: synchronous memory of MAC/IP pairs with per-entry valid flags and a fill count.
// Depends on arpsd_pkg.
module arpsd_bind_tbl import arpsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bind_req_t req_i,
  output bind_rsp_t rsp_o
);

  logic [MAC_W+IP_W-1:0] mem_q [TABLE_DEPTH];
  logic [MAC_W+IP_W-1:0] rdata_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   rvalid_q;
  logic [TBL_CW-1:0]      count_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= {req_i.wr_mac, req_i.wr_ip};
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.wr_en && req_i.set_valid) begin
        valid_q[req_i.wr_addr] <= 1'b1;
        count_q                <= count_q + 1'b1;
      end
    end
  end

  assign rsp_o.rd_mac   = rdata_q[MAC_W+IP_W-1:IP_W];
  assign rsp_o.rd_ip    = rdata_q[IP_W-1:0];
  assign rsp_o.rd_valid = rvalid_q;
  assign rsp_o.count    = count_q;

endmodule

// ===== src/arpsd_rpt_set.sv =====
// Reported-address set: synchronous memory filled in order, with a count that stops when full.
// Depends on arpsd_pkg.
module arpsd_rpt_set import arpsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rpt_req_t req_i,
  output rpt_rsp_t rsp_o
);

  logic [IP_W-1:0]   mem_q [REPORT_DEPTH];
  logic [IP_W-1:0]   rdata_q;
  logic [RPT_CW-1:0] count_q;
  logic              room;

  assign room = (count_q != RPT_CW'(REPORT_DEPTH));

  always_ff @(posedge clk_i) begin
    if (req_i.append && room) begin
      mem_q[count_q[RPT_AW-1:0]] <= req_i.wr_ip;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (req_i.append && room) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign rsp_o.rd_ip = rdata_q;
  assign rsp_o.count = count_q;

endmodule

// ===== src/arp_binding_spoof_detector_top.sv =====
// Top level of the ARP binding spoof detector: item sequencer around the two stores.
// Depends on arpsd_pkg, arpsd_bind_tbl and arpsd_rpt_set.
//
// Usage: drive one parsed ARP frame on item_i and raise start_i; the beat is
// taken at a rising edge where start_i is high and busy_o is low. busy_o stays
// high until the result is produced, so the block holds one item at a time.
// The result beat appears on result_o for exactly one cycle, marked by done_o,
// and the receiver cannot stall it. A new item may be started in that cycle.
// A frame that is not a reply, or a learn mismatch, goes straight to the result
// state. Other items scan the binding memory one entry per cycle through its
// single read port and then decide; a check whose MAC is bound to another IP
// then scans the reported-address memory the same way before the result.
// Reset empties the binding table (valid flags and count) and the reported set
// at once; no clearing pass is needed and an item may start right after reset.
module arp_binding_spoof_detector_top import arpsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  arpsd_in_t  item_i,
  output logic       busy_o,
  output logic       done_o,
  output arpsd_out_t result_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_BSCAN   = 6'b000010,
    S_DECIDE  = 6'b000100,
    S_RSCAN   = 6'b001000,
    S_RDECIDE = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  arpsd_in_t         item_q, item_d;
  logic [SCAN_W-1:0] cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [TBL_AW-1:0] idx_q, idx_d;
  logic              hit_q, hit_d;
  logic [TBL_AW-1:0] hit_idx_q, hit_idx_d;
  logic [IP_W-1:0]   hit_ip_q, hit_ip_d;
  logic              free_q, free_d;
  logic [TBL_AW-1:0] free_idx_q, free_idx_d;
  logic              lfound_q, lfound_d;
  logic [MAC_W-1:0]  lmac_q, lmac_d;
  logic              rep_q, rep_d;
  status_e           status_q, status_d;
  logic              done_q, done_d;
  arpsd_out_t        result_q, result_d;

  bind_req_t bind_req;
  bind_rsp_t bind_rsp;
  rpt_req_t  rpt_req;
  rpt_rsp_t  rpt_rsp;

  arpsd_bind_tbl u_bind_tbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bind_req),
    .rsp_o  (bind_rsp)
  );

  arpsd_rpt_set u_rpt_set (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rpt_req),
    .rsp_o  (rpt_rsp)
  );

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_ip_d   = hit_ip_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    lfound_d   = lfound_q;
    lmac_d     = lmac_q;
    rep_d      = rep_q;
    status_d   = status_q;
    done_d     = 1'b0;
    result_d   = result_q;

    bind_req           = '0;
    bind_req.rd_addr   = cnt_q[TBL_AW-1:0];
    bind_req.wr_mac    = item_q.sender_mac;
    bind_req.wr_ip     = item_q.sender_ip;
    rpt_req            = '0;
    rpt_req.rd_addr    = cnt_q[RPT_AW-1:0];
    rpt_req.wr_ip      = item_q.sender_ip;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d   = item_i;
          cnt_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          lfound_d = 1'b0;
          lmac_d   = '0;
          rep_d    = 1'b0;
          if (item_i.opcode != OP_REPLY) begin
            status_d = ST_NOT_REPLY;
            state_d  = S_RESP;
          end else if (item_i.func == FUNC_LEARN && item_i.sender_ip != item_i.probed_ip) begin
            status_d = ST_MISMATCH;
            state_d  = S_RESP;
          end else begin
            state_d = S_BSCAN;
          end
        end
      end
      S_BSCAN: begin
        if (rd_vld_q) begin
          if (bind_rsp.rd_valid) begin
            if (!hit_q && bind_rsp.rd_mac == item_q.sender_mac) begin
              hit_d     = 1'b1;
              hit_idx_d = idx_q;
              hit_ip_d  = bind_rsp.rd_ip;
            end
            if (bind_rsp.rd_ip == item_q.sender_ip && (!lfound_q || bind_rsp.rd_mac < lmac_q)) begin
              lfound_d = 1'b1;
              lmac_d   = bind_rsp.rd_mac;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q;
          end
        end
        if (cnt_q == SCAN_W'(TABLE_DEPTH)) begin
          state_d = S_DECIDE;
        end else begin
          bind_req.rd_en = 1'b1;
          rd_vld_d       = 1'b1;
          idx_d          = cnt_q[TBL_AW-1:0];
          cnt_d          = cnt_q + 1'b1;
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        if (item_q.func == FUNC_LEARN) begin
          if (hit_q) begin
            bind_req.wr_en   = 1'b1;
            bind_req.wr_addr = hit_idx_q;
            status_d         = ST_UPDATED;
          end else if (free_q) begin
            bind_req.wr_en     = 1'b1;
            bind_req.set_valid = 1'b1;
            bind_req.wr_addr   = free_idx_q;
            status_d           = ST_LEARNED;
          end else begin
            status_d = ST_FULL;
          end
        end else if (!hit_q) begin
          status_d = ST_NEW_DEVICE;
        end else if (hit_ip_q == item_q.sender_ip) begin
          status_d = ST_CONSISTENT;
        end else begin
          cnt_d   = '0;
          state_d = S_RSCAN;
        end
      end
      S_RSCAN: begin
        if (rd_vld_q && rpt_rsp.rd_ip == item_q.sender_ip) begin
          rep_d = 1'b1;
        end
        if (cnt_q == SCAN_W'(rpt_rsp.count)) begin
          state_d = S_RDECIDE;
        end else begin
          rpt_req.rd_en = 1'b1;
          rd_vld_d      = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
      end
      S_RDECIDE: begin
        state_d = S_RESP;
        if (rep_q) begin
          status_d = ST_REPORTED;
        end else begin
          status_d       = ST_ALERT;
          rpt_req.append = 1'b1;
        end
      end
      S_RESP: begin
        state_d              = S_IDLE;
        done_d               = 1'b1;
        result_d.status      = status_q;
        result_d.legit_mac   = (status_q == ST_ALERT) ? lmac_q : '0;
        result_d.legit_found = (status_q == ST_ALERT) ? lfound_q : 1'b0;
        result_d.entry_count = bind_rsp.count;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_ip_q   <= hit_ip_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    lfound_q   <= lfound_d;
    lmac_q     <= lmac_d;
    rep_q      <= rep_d;
    status_q   <= status_d;
    result_q   <= result_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== src/arpsd_chk.sv =====
// Port-level checker for the ARP binding spoof detector, attached to the top level by bind.
// Depends on arpsd_pkg and arp_binding_spoof_detector_top.
module arpsd_chk import arpsd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input arpsd_out_t result_o
);

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Block stayed idle after taking an input beat.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result beat lasted more than one cycle.");

  a_busy_ends_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("Block went idle without delivering a result beat.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.entry_count <= TBL_CW'(TABLE_DEPTH)))
    else $error("Entry count exceeds the table depth.");

  a_legit_only_on_alert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_ALERT) |->
      (result_o.legit_mac == '0 && !result_o.legit_found))
    else $error("Legitimate MAC reported outside an alert.");

endmodule

bind arp_binding_spoof_detector_top arpsd_chk u_arpsd_chk (.*);

// ===== sim/tb_arp_binding_spoof_detector_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for arp_binding_spoof_detector_top: directed frames, then random scans and checks.
// Beats are checked against typed rows or a binding-table model kept here; needs arpsd_pkg and the top.
module tb_arp_binding_spoof_detector_top;
  import arpsd_pkg::*;

  typedef struct {
    arpsd_in_t  frm;
    bit         typed;
    arpsd_out_t want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  arpsd_in_t  item_i;
  logic       busy_o;
  logic       done_o;
  arpsd_out_t result_o;

  logic [MAC_W-1:0]  tbl_mac [TABLE_DEPTH];
  logic [IP_W-1:0]   tbl_ip  [TABLE_DEPTH];
  bit                tbl_vld [TABLE_DEPTH];
  logic [TBL_CW-1:0] tbl_cnt;
  logic [IP_W-1:0]   rpt_ip  [REPORT_DEPTH];
  int                rpt_cnt;

  arpsd_out_t verdict_q[$];
  dir_row_t   dir_rows[$];
  int         fails;
  bit         idle_en;

  always #5 clk_i = ~clk_i;

  arp_binding_spoof_detector_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  function automatic int bound_slot(input logic [MAC_W-1:0] mac);
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_vld[i] && tbl_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic arpsd_out_t arp_inspect(input arpsd_in_t f);
    arpsd_out_t r;
    int         slot;
    int         i;
    bit         seen;
    r = '0;
    r.status = ST_NOT_REPLY;
    if (f.opcode == OP_REPLY) begin
      if (f.func == FUNC_LEARN) begin
        if (f.sender_ip != f.probed_ip) begin
          r.status = ST_MISMATCH;
        end else begin
          slot = bound_slot(f.sender_mac);
          if (slot >= 0) begin
            tbl_ip[slot] = f.sender_ip;
            r.status = ST_UPDATED;
          end else begin
            for (i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
              if (!tbl_vld[i]) slot = i;
            end
            if (slot < 0) begin
              r.status = ST_FULL;
            end else begin
              tbl_mac[slot] = f.sender_mac;
              tbl_ip[slot]  = f.sender_ip;
              tbl_vld[slot] = 1'b1;
              tbl_cnt++;
              r.status = ST_LEARNED;
            end
          end
        end
      end else begin
        slot = bound_slot(f.sender_mac);
        seen = 1'b0;
        for (i = 0; i < rpt_cnt; i++) begin
          if (rpt_ip[i] == f.sender_ip) seen = 1'b1;
        end
        if (slot < 0) begin
          r.status = ST_NEW_DEVICE;
        end else if (tbl_ip[slot] == f.sender_ip) begin
          r.status = ST_CONSISTENT;
        end else if (seen) begin
          r.status = ST_REPORTED;
        end else begin
          r.status = ST_ALERT;
          for (i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_vld[i] && tbl_ip[i] == f.sender_ip &&
                (!r.legit_found || tbl_mac[i] < r.legit_mac)) begin
              r.legit_mac   = tbl_mac[i];
              r.legit_found = 1'b1;
            end
          end
          if (rpt_cnt < REPORT_DEPTH) begin
            rpt_ip[rpt_cnt] = f.sender_ip;
            rpt_cnt++;
          end
        end
      end
    end
    r.entry_count = tbl_cnt;
    return r;
  endfunction

  function automatic void add_row(input func_e fn, input logic [OPC_W-1:0] opc,
                                  input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] sip,
                                  input logic [IP_W-1:0] pip, input bit typed,
                                  input status_e st, input logic [MAC_W-1:0] lmac,
                                  input bit lfound, input int cnt);
    dir_row_t row;
    row.frm.func       = fn;
    row.frm.opcode     = opc;
    row.frm.sender_mac = mac;
    row.frm.sender_ip  = sip;
    row.frm.probed_ip  = pip;
    row.typed              = typed;
    row.want.status        = st;
    row.want.legit_mac     = lmac;
    row.want.legit_found   = lfound;
    row.want.entry_count   = cnt[TBL_CW-1:0];
    dir_rows.push_back(row);
  endfunction

  task automatic send_frame(input arpsd_in_t frm, input bit typed, input arpsd_out_t want);
    bit         taken;
    arpsd_out_t got;
    taken = 1'b0;
    item_i <= frm;
    while (!taken) begin
      if (idle_en && $urandom_range(99) < 27) start_i <= 1'b0;
      else start_i <= 1'b1;
      @(posedge clk_i);
      taken = start_i && !busy_o;
    end
    got = arp_inspect(frm);
    verdict_q.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    arpsd_out_t want;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no frame outstanding");
        fails++;
      end else begin
        want = verdict_q.pop_front();
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          fails++;
        end
        if (result_o.legit_mac !== want.legit_mac) begin
          $error("legit_mac: expected %h, got %h", want.legit_mac, result_o.legit_mac);
          fails++;
        end
        if (result_o.legit_found !== want.legit_found) begin
          $error("legit_found: expected %0d, got %0d", want.legit_found,
                 result_o.legit_found);
          fails++;
        end
        if (result_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 result_o.entry_count);
          fails++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("arp_binding_spoof_detector_top test failed");
    $finish;
  end

  initial begin
    logic [MAC_W-1:0] mac_pool [80];
    logic [IP_W-1:0]  ip_pool  [24];
    logic [159:0]     raw;
    arpsd_in_t        frm;
    arpsd_out_t       none;
    int               sent;
    int               pick;
    int               i;

    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    item_i  <= '0;
    fails   = 0;
    idle_en = 1'b1;
    none    = '0;
    tbl_cnt = '0;
    rpt_cnt = 0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      tbl_mac[i] = '0;
      tbl_ip[i]  = '0;
      tbl_vld[i] = 1'b0;
    end
    for (i = 0; i < REPORT_DEPTH; i++) rpt_ip[i] = '0;

    add_row(FUNC_CHECK, OP_REPLY, 48'h1, 32'h1, 32'h0, 1, ST_NEW_DEVICE, 48'h0, 0, 0);
    add_row(FUNC_LEARN, 16'h0, '1, '1, '1, 1, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_CHECK, 16'hFFFF, '1, '1, '1, 1, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_LEARN, 16'h3, 48'h5, 32'h7, 32'h7, 1, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_LEARN, OP_REPLY, 48'h5, 32'h0A00_0001, 32'h0A00_0002, 1, ST_MISMATCH,
            48'h0, 0, 0);
    add_row(FUNC_LEARN, OP_REPLY, '1, '1, '1, 1, ST_LEARNED, 48'h0, 0, 1);
    add_row(FUNC_LEARN, OP_REPLY, '0, '0, '0, 1, ST_LEARNED, 48'h0, 0, 2);
    add_row(FUNC_LEARN, OP_REPLY, '0, '1, '1, 1, ST_UPDATED, 48'h0, 0, 2);
    add_row(FUNC_CHECK, OP_REPLY, '0, '1, '0, 1, ST_CONSISTENT, 48'h0, 0, 2);
    add_row(FUNC_CHECK, OP_REPLY, '1, '0, '1, 1, ST_ALERT, 48'h0, 0, 2);
    add_row(FUNC_CHECK, OP_REPLY, '1, '0, '0, 1, ST_REPORTED, 48'h0, 0, 2);
    add_row(FUNC_CHECK, OP_REPLY, '1, '1, '1, 1, ST_CONSISTENT, 48'h0, 0, 2);
    add_row(FUNC_LEARN, OP_REPLY, 48'h9, 32'hC0A8_0001, 32'hC0A8_0001, 0, ST_NOT_REPLY,
            48'h0, 0, 0);
    add_row(FUNC_LEARN, OP_REPLY, 48'h3, 32'hC0A8_0001, 32'hC0A8_0001, 0, ST_NOT_REPLY,
            48'h0, 0, 0);
    add_row(FUNC_LEARN, OP_REPLY, 48'h7, 32'hC0A8_0001, 32'hC0A8_0001, 0, ST_NOT_REPLY,
            48'h0, 0, 0);
    add_row(FUNC_CHECK, OP_REPLY, '0, 32'hC0A8_0001, '1, 0, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_CHECK, OP_REPLY, 48'h9, 32'hC0A8_0001, '0, 0, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_CHECK, OP_REPLY, 48'h9, 32'hC0A8_0002, '0, 0, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_LEARN, OP_REPLY, 48'h1234_5678_9ABC, 32'hC0A8_0001, 32'hC0A8_0001, 0,
            ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_CHECK, OP_REPLY, 48'h3, '1, '0, 0, ST_NOT_REPLY, 48'h0, 0, 0);
    add_row(FUNC_CHECK, OP_REPLY, 48'h1234_5678_9ABC, 32'hC0A8_0001, 32'h0, 0,
            ST_CONSISTENT, 48'h0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_frame(dir_rows[k].frm, dir_rows[k].typed, dir_rows[k].want);
    drain_results();

    for (i = 0; i < 80; i++) mac_pool[i] = 48'({$urandom, $urandom});
    for (i = 0; i < 24; i++) ip_pool[i] = $urandom;

    sent = 0;
    while (sent < 1700) begin
      idle_en = !(sent >= 700 && sent < 1000);
      if (sent == 1200) drain_results();
      pick = $urandom_range(99);
      raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
      frm  = raw[$bits(arpsd_in_t)-1:0];
      if (pick >= 8) begin
        frm.opcode = OP_REPLY;
        if (pick < 12) begin
          frm.func = FUNC_LEARN;
          if (frm.probed_ip == frm.sender_ip) frm.probed_ip = ~frm.sender_ip;
        end else if (pick < 50) begin
          frm.func       = FUNC_LEARN;
          frm.sender_mac = mac_pool[$urandom_range(79)];
          frm.sender_ip  = ip_pool[$urandom_range(23)];
          frm.probed_ip  = frm.sender_ip;
        end else begin
          frm.func = FUNC_CHECK;
          if ($urandom_range(99) < 85) frm.sender_mac = mac_pool[$urandom_range(79)];
          if ($urandom_range(99) < 70) frm.sender_ip = ip_pool[$urandom_range(23)];
        end
      end
      sent++;
      send_frame(frm, 1'b0, none);
    end

    start_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("arp_binding_spoof_detector_top test passed");
    end else begin
      $display("arp_binding_spoof_detector_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/arpsd_pkg.sv
src/arpsd_bind_tbl.sv
src/arpsd_rpt_set.sv
src/arp_binding_spoof_detector_top.sv
src/arpsd_chk.sv
sim/tb_arp_binding_spoof_detector_top.sv
